// ===== hw/rtl/nec_ir_pkg.sv =====
// Shared types and constants for the NEC infrared frame decoder.
// Holds the status codes, the register indexes and the window types.
// No dependencies.
package nec_ir_pkg;

    // One duration window: minimum in bits 15:0, maximum in bits 31:16.
    typedef struct packed {
        logic [15:0] hi;
        logic [15:0] lo;
    } t_window;

    typedef struct packed {
        t_window lead_pulse;
        t_window lead_space;
        t_window mark;
        t_window one_space;
        t_window zero_space;
    } t_windows;

    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_LEAD_PULSE = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LEAD_SPACE = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MARK       = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ONE_SPACE  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ZERO_SPACE = 3'd4;

    localparam logic [31:0] RST_LEAD_PULSE = 32'd655368000;
    localparam logic [31:0] RST_LEAD_SPACE = 32'd327684000;
    localparam logic [31:0] RST_MARK       = 32'd45875600;
    localparam logic [31:0] RST_ONE_SPACE  = 32'd124519800;
    localparam logic [31:0] RST_ZERO_SPACE = 32'd45875600;

    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_SHORT      = 4'd1;
    localparam logic [3:0] ST_LEAD_PULSE = 4'd2;
    localparam logic [3:0] ST_LEAD_SPACE = 4'd3;
    localparam logic [3:0] ST_DATA_PULSE = 4'd4;
    localparam logic [3:0] ST_DATA_SPACE = 4'd5;
    localparam logic [3:0] ST_TRAILER    = 4'd6;
    localparam logic [3:0] ST_ADDRESS    = 4'd7;
    localparam logic [3:0] ST_COMMAND    = 4'd8;

    // Sample positions within one waveform.
    localparam logic [6:0] FRAME_SAMPLES = 7'd67;
    localparam logic [6:0] TRAILER_INDEX = 7'd66;
    localparam logic [6:0] FIRST_SPACE   = 7'd3;

    localparam int OUT_TDATA_BITS = 24;

endpackage

// ===== hw/rtl/nec_ir_frame_decoder_top.sv =====
// Top level of the NEC infrared frame decoder.
// Depends on nec_ir_pkg, nec_ir_cfg, nec_ir_in_reg and nec_ir_decode.
//
//  channel   direction  handshake              payload
//  s_axis    in         s_axis_tvalid/tready   tdata: duration; tlast: last sample
//  m_axis    out        m_axis_tvalid/tready   tdata: status, address, command
//  cfg       in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One duration beat per cycle is taken unless a waiting result stalls it; a beat
// is held in the input register, then its status (if any) in the result register.
// Window compares and the bit insert sit in one stage between those registers.
// A waiting result stalls only beats that would decide a status.
// Reset is synchronous: windows return to their defaults, frame state clears.
module nec_ir_frame_decoder_top #(
    parameter int DURATION_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // duration [DURATION_BITS-1:0], zero fill to whole bytes
    input  logic [((DURATION_BITS+7)/8)*8-1:0]    s_axis_tdata,
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // status [3:0], address [11:4], command [19:12], zero [23:20]
    output logic [nec_ir_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [nec_ir_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [31:0]                           i_cfg_data
);

    nec_ir_pkg::t_windows      windows;
    logic                      take;
    logic                      in_valid;
    logic [DURATION_BITS-1:0]  in_duration;
    logic                      in_last;
    logic [3:0]                status;
    logic [7:0]                address;
    logic [7:0]                command;

    nec_ir_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_windows   (windows)
    );

    nec_ir_in_reg #(
        .DURATION_BITS (DURATION_BITS)
    ) u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_duration (s_axis_tdata[DURATION_BITS-1:0]),
        .i_last     (s_axis_tlast),
        .i_take     (take),
        .o_valid    (in_valid),
        .o_duration (in_duration),
        .o_last     (in_last)
    );

    nec_ir_decode #(
        .DURATION_BITS (DURATION_BITS)
    ) u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_windows  (windows),
        .i_valid    (in_valid),
        .i_duration (in_duration),
        .i_last     (in_last),
        .o_take     (take),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_status   (status),
        .o_address  (address),
        .o_command  (command)
    );

    assign m_axis_tdata = {4'd0, command, address, status};

endmodule

// ===== hw/rtl/nec_ir_cfg.sv =====
// Window register file of the NEC infrared frame decoder.
// Depends on nec_ir_pkg for the window types and register indexes.
module nec_ir_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [nec_ir_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [31:0]                         i_cfg_data,
    output nec_ir_pkg::t_windows                o_windows
);

    nec_ir_pkg::t_windows r_windows;

    assign o_cfg_ready = 1'b1;
    assign o_windows   = r_windows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_windows.lead_pulse <= nec_ir_pkg::RST_LEAD_PULSE;
            r_windows.lead_space <= nec_ir_pkg::RST_LEAD_SPACE;
            r_windows.mark       <= nec_ir_pkg::RST_MARK;
            r_windows.one_space  <= nec_ir_pkg::RST_ONE_SPACE;
            r_windows.zero_space <= nec_ir_pkg::RST_ZERO_SPACE;
        end else if (i_cfg_valid) begin
            // Indexes beyond the list are dropped.
            case (i_cfg_index)
                nec_ir_pkg::CFG_LEAD_PULSE: r_windows.lead_pulse <= i_cfg_data;
                nec_ir_pkg::CFG_LEAD_SPACE: r_windows.lead_space <= i_cfg_data;
                nec_ir_pkg::CFG_MARK:       r_windows.mark       <= i_cfg_data;
                nec_ir_pkg::CFG_ONE_SPACE:  r_windows.one_space  <= i_cfg_data;
                nec_ir_pkg::CFG_ZERO_SPACE: r_windows.zero_space <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/nec_ir_in_reg.sv =====
// Input register of the NEC infrared frame decoder: holds one duration beat.
// Depends on nothing but its parameter.
module nec_ir_in_reg #(
    parameter int DURATION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [DURATION_BITS-1:0] i_duration,
    input  logic                     i_last,
    input  logic                     i_take,
    output logic                     o_valid,
    output logic [DURATION_BITS-1:0] o_duration,
    output logic                     o_last
);

    logic                     r_valid;
    logic [DURATION_BITS-1:0] r_duration;
    logic                     r_last;

    assign o_ready    = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_duration = r_duration;
    assign o_last     = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_duration <= i_duration;
            r_last     <= i_last;
        end
    end

endmodule

// ===== hw/rtl/nec_ir_decode.sv =====
// Frame state, window checks and result register of the NEC infrared decoder.
// Depends on nec_ir_pkg for windows, status codes and sample positions.
module nec_ir_decode #(
    parameter int DURATION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  nec_ir_pkg::t_windows     i_windows,
    input  logic                     i_valid,
    input  logic [DURATION_BITS-1:0] i_duration,
    input  logic                     i_last,
    output logic                     o_take,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [3:0]               o_status,
    output logic [7:0]               o_address,
    output logic [7:0]               o_command
);

    localparam int CW = (DURATION_BITS > 16) ? DURATION_BITS : 16;

    logic [6:0]  r_count;
    logic [31:0] r_bits;
    logic        r_decided;
    logic        r_out_valid;
    logic [3:0]  r_status;
    logic [7:0]  r_address;
    logic [7:0]  r_command;

    logic [6:0]  n_count;
    logic [31:0] n_bits;
    logic        n_decided;
    logic        emit;
    logic [3:0]  status;
    logic [7:0]  addr;
    logic [7:0]  cmd;
    logic [CW-1:0] dur;
    logic [4:0]  bit_idx;
    logic [6:0]  space_off;
    logic        out_free;

    function automatic logic in_win(input logic [CW-1:0] d, input nec_ir_pkg::t_window w);
        return (d >= CW'(w.lo)) && (d <= CW'(w.hi));
    endfunction

    assign dur       = CW'(i_duration);
    assign space_off = r_count - nec_ir_pkg::FIRST_SPACE;
    assign bit_idx   = space_off[5:1];
    assign out_free  = !r_out_valid || i_ready;
    // Beats that decide nothing pass even while a result waits.
    assign o_take    = i_valid && (!emit || out_free);

    always_comb begin
        emit      = 1'b0;
        status    = nec_ir_pkg::ST_OK;
        addr      = 8'd0;
        cmd       = 8'd0;
        n_bits    = (r_count == 7'd0) ? 32'd0 : r_bits;
        n_count   = r_count;
        n_decided = r_decided;
        if (!r_decided) begin
            priority if (i_last && r_count < nec_ir_pkg::TRAILER_INDEX) begin
                emit   = 1'b1;
                status = nec_ir_pkg::ST_SHORT;
            end else if (r_count == 7'd0) begin
                if (!in_win(dur, i_windows.lead_pulse)) begin
                    emit   = 1'b1;
                    status = nec_ir_pkg::ST_LEAD_PULSE;
                end
            end else if (r_count == 7'd1) begin
                if (!in_win(dur, i_windows.lead_space)) begin
                    emit   = 1'b1;
                    status = nec_ir_pkg::ST_LEAD_SPACE;
                end
            end else if (r_count < nec_ir_pkg::TRAILER_INDEX) begin
                if (!r_count[0]) begin
                    if (!in_win(dur, i_windows.mark)) begin
                        emit   = 1'b1;
                        status = nec_ir_pkg::ST_DATA_PULSE;
                    end
                end else if (in_win(dur, i_windows.one_space)) begin
                    n_bits[bit_idx] = 1'b1;
                end else if (!in_win(dur, i_windows.zero_space)) begin
                    emit   = 1'b1;
                    status = nec_ir_pkg::ST_DATA_SPACE;
                end
            end else begin
                emit = 1'b1;
                priority if (!in_win(dur, i_windows.mark)) begin
                    status = nec_ir_pkg::ST_TRAILER;
                end else if (r_bits[7:0] != ~r_bits[15:8]) begin
                    status = nec_ir_pkg::ST_ADDRESS;
                end else if (r_bits[23:16] != ~r_bits[31:24]) begin
                    status = nec_ir_pkg::ST_COMMAND;
                end else begin
                    status = nec_ir_pkg::ST_OK;
                    addr   = r_bits[7:0];
                    cmd    = r_bits[23:16];
                end
            end
            if (emit) begin
                n_decided = 1'b1;
            end else if (r_count < nec_ir_pkg::FRAME_SAMPLES) begin
                n_count = r_count + 7'd1;
            end
        end
        // The last beat always rearms for the next waveform.
        if (i_last) begin
            n_count   = 7'd0;
            n_decided = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= 7'd0;
            r_bits      <= 32'd0;
            r_decided   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_count   <= n_count;
                r_decided <= n_decided;
                if (!r_decided) begin
                    r_bits <= n_bits;
                end
            end
            if (o_take && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && emit) begin
            r_status  <= status;
            r_address <= addr;
            r_command <= cmd;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_status  = r_status;
    assign o_address = r_address;
    assign o_command = r_command;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= nec_ir_pkg::FRAME_SAMPLES)
        else $error("sample count beyond frame length");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != nec_ir_pkg::ST_OK) |-> (r_address == 8'd0 && r_command == 8'd0))
        else $error("failed frame carries address or command");

    a_last_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_last) |=> (r_count == 7'd0 && !r_decided))
        else $error("last beat did not rearm the frame state");

    a_emit_decides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && emit && !i_last) |=> (r_decided && r_out_valid))
        else $error("result issued without marking the frame decided");

    a_no_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_decided |-> !emit)
        else $error("second result for one waveform");

endmodule

// ===== test/tb.sv =====
// Self-checking bench for nec_ir_frame_decoder_top: infrared waveforms of duration beats.
// Holds its own frame decoder to predict each status beat; depends on nec_ir_pkg.
`timescale 1ns / 1ps

module tb;

    localparam int DUR_BITS      = 16;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 4;
    localparam int STUCK_LIMIT   = 5000;
    localparam int BEAT_TARGET   = 1700;
    localparam int WAVE_TARGET   = 20;
    localparam int PHASE_BEATS   = 180;

    // no register sits at this index; writes to it must change nothing
    localparam logic [nec_ir_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE = 3'd7;

    typedef enum logic [1:0] {
        ITEM_SAMPLE,
        ITEM_WRITE,
        ITEM_SETTLE
    } t_item_kind;

    typedef struct packed {
        t_item_kind                            kind;
        logic [DUR_BITS-1:0]                   duration;
        logic                                  last;
        logic [nec_ir_pkg::CFG_INDEX_BITS-1:0] reg_index;
        logic [31:0]                           reg_data;
    } t_bench_item;

    typedef struct packed {
        logic [3:0] status;
        logic [7:0] address;
        logic [7:0] command;
    } t_frame_status;

    logic                                  i_clk         = 1'b0;
    logic                                  i_rst_n       = 1'b0;
    logic                                  s_axis_tvalid = 1'b0;
    logic                                  s_axis_tready;
    logic [DUR_BITS-1:0]                   s_axis_tdata  = '0;
    logic                                  s_axis_tlast  = 1'b0;
    logic                                  m_axis_tvalid;
    logic                                  m_axis_tready = 1'b0;
    logic [nec_ir_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata;
    logic                                  i_cfg_valid   = 1'b0;
    logic                                  o_cfg_ready;
    logic [nec_ir_pkg::CFG_INDEX_BITS-1:0] i_cfg_index   = '0;
    logic [31:0]                           i_cfg_data    = '0;

    nec_ir_frame_decoder_top #(
        .DURATION_BITS(DUR_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // planned traffic and the windows it was planned against
    t_bench_item          waveform_q[$];
    nec_ir_pkg::t_windows plan_win;
    int                   beats_planned = 0;
    int                   waves_planned = 0;

    // decoder copy: windows as written, frame progress, awaited statuses
    nec_ir_pkg::t_windows live_win;
    logic [6:0]    frame_pos   = '0;
    logic [31:0]   bits_seen   = '0;
    logic          frame_done  = 1'b0;
    t_frame_status awaited_status_q[$];

    int            gap_left      = 0;
    int            burst_left    = 1;
    int            quiet_run     = 0;
    int            beats_taken   = 0;
    int            waves_taken   = 0;
    int            writes_taken  = 0;
    int            settles_done  = 0;
    int            statuses_seen = 0;
    int            failures      = 0;
    int            stuck_cycles  = 0;
    logic [31:0]   cycle_count   = '0;
    logic [8:0]    codes_seen    = '0;

    function automatic logic in_win(logic [DUR_BITS-1:0] d, nec_ir_pkg::t_window w);
        return d >= w.lo && d <= w.hi;
    endfunction

    function automatic nec_ir_pkg::t_windows window_write(nec_ir_pkg::t_windows w,
                                                          logic [2:0] idx,
                                                          logic [31:0] data);
        case (idx)
            nec_ir_pkg::CFG_LEAD_PULSE: w.lead_pulse = data;
            nec_ir_pkg::CFG_LEAD_SPACE: w.lead_space = data;
            nec_ir_pkg::CFG_MARK:       w.mark       = data;
            nec_ir_pkg::CFG_ONE_SPACE:  w.one_space  = data;
            nec_ir_pkg::CFG_ZERO_SPACE: w.zero_space = data;
            default: ;
        endcase
        return w;
    endfunction

    task automatic decode_duration(input logic [DUR_BITS-1:0] d, input logic last);
        t_frame_status res;
        logic          emit;
        logic [7:0]    addr, addr_n, cmd, cmd_n;
        res  = '0;
        emit = 1'b0;
        if (!frame_done) begin
            if (frame_pos == 0) bits_seen = '0;
            {cmd_n, cmd, addr_n, addr} = bits_seen;
            // an early last mark wins over the window test of its own sample
            if (last && frame_pos < nec_ir_pkg::TRAILER_INDEX) begin
                res.status = nec_ir_pkg::ST_SHORT;
                emit       = 1'b1;
            end else if (frame_pos == 0) begin
                if (!in_win(d, live_win.lead_pulse)) begin
                    res.status = nec_ir_pkg::ST_LEAD_PULSE;
                    emit       = 1'b1;
                end
            end else if (frame_pos == 1) begin
                if (!in_win(d, live_win.lead_space)) begin
                    res.status = nec_ir_pkg::ST_LEAD_SPACE;
                    emit       = 1'b1;
                end
            end else if (frame_pos < nec_ir_pkg::TRAILER_INDEX && !frame_pos[0]) begin
                if (!in_win(d, live_win.mark)) begin
                    res.status = nec_ir_pkg::ST_DATA_PULSE;
                    emit       = 1'b1;
                end
            end else if (frame_pos < nec_ir_pkg::TRAILER_INDEX) begin
                // the one window takes a space that both windows hold
                if (in_win(d, live_win.one_space)) begin
                    bits_seen[(frame_pos - nec_ir_pkg::FIRST_SPACE) >> 1] = 1'b1;
                end else if (!in_win(d, live_win.zero_space)) begin
                    res.status = nec_ir_pkg::ST_DATA_SPACE;
                    emit       = 1'b1;
                end
            end else begin
                emit = 1'b1;
                if (!in_win(d, live_win.mark)) begin
                    res.status = nec_ir_pkg::ST_TRAILER;
                end else if (addr != ~addr_n) begin
                    res.status = nec_ir_pkg::ST_ADDRESS;
                end else if (cmd != ~cmd_n) begin
                    res.status = nec_ir_pkg::ST_COMMAND;
                end else begin
                    res.status  = nec_ir_pkg::ST_OK;
                    res.address = addr;
                    res.command = cmd;
                end
            end
            if (emit) begin
                frame_done = 1'b1;
                awaited_status_q.push_back(res);
            end else if (frame_pos < nec_ir_pkg::FRAME_SAMPLES) begin
                frame_pos = frame_pos + 7'd1;
            end
        end
        if (last) begin
            frame_pos  = '0;
            frame_done = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------- planning

    function automatic logic [DUR_BITS-1:0] dur_inside(nec_ir_pkg::t_window w);
        if (w.lo > w.hi) return DUR_BITS'($urandom_range(0, 65535));
        case ($urandom_range(0, 5))
            0:       return w.lo;
            1:       return w.hi;
            default: return DUR_BITS'($urandom_range(w.lo, w.hi));
        endcase
    endfunction

    function automatic logic [DUR_BITS-1:0] dur_outside(nec_ir_pkg::t_window w);
        if (w.lo > w.hi || (w.lo == 0 && w.hi == 16'hffff))
            return DUR_BITS'($urandom_range(0, 65535));
        if (w.hi == 16'hffff || (w.lo != 0 && $urandom_range(0, 1) == 1))
            return $urandom_range(0, 1) ? w.lo - 16'd1 : DUR_BITS'($urandom_range(0, w.lo - 1));
        return $urandom_range(0, 1) ? w.hi + 16'd1 : DUR_BITS'($urandom_range(w.hi + 1, 65535));
    endfunction

    function automatic logic [DUR_BITS-1:0] good_sample(int pos, logic [31:0] bits);
        logic [DUR_BITS-1:0] d;
        if (pos == 0) return dur_inside(plan_win.lead_pulse);
        if (pos == 1) return dur_inside(plan_win.lead_space);
        if (!pos[0]) return dur_inside(plan_win.mark);
        if (bits[(pos - 3) / 2]) return dur_inside(plan_win.one_space);
        // keep a zero space clear of the one window when the windows allow it
        for (int k = 0; k < 8; k++) begin
            d = dur_inside(plan_win.zero_space);
            if (!in_win(d, plan_win.one_space)) break;
        end
        return d;
    endfunction

    function automatic logic [DUR_BITS-1:0] flawed_sample(int pos);
        logic [DUR_BITS-1:0] d;
        if (pos == 0) return dur_outside(plan_win.lead_pulse);
        if (pos == 1) return dur_outside(plan_win.lead_space);
        if (!pos[0]) return dur_outside(plan_win.mark);
        for (int k = 0; k < 8; k++) begin
            d = $urandom_range(0, 1) ? dur_outside(plan_win.one_space)
                                     : dur_outside(plan_win.zero_space);
            if (!in_win(d, plan_win.one_space) && !in_win(d, plan_win.zero_space)) break;
        end
        return d;
    endfunction

    function automatic logic [31:0] rand_window(int lo_min, int lo_max, int span_max);
        int lo;
        int hi;
        lo = $urandom_range(lo_min, lo_max);
        hi = lo + $urandom_range(0, span_max);
        if (hi > 65535) hi = 65535;
        return {16'(hi), 16'(lo)};
    endfunction

    task automatic plan_sample(input logic [DUR_BITS-1:0] d, input logic last);
        waveform_q.push_back('{kind: ITEM_SAMPLE, duration: d, last: last,
                               reg_index: '0, reg_data: '0});
        beats_planned++;
        if (last) waves_planned++;
    endtask

    task automatic plan_write(input logic [nec_ir_pkg::CFG_INDEX_BITS-1:0] idx,
                              input logic [31:0] data);
        waveform_q.push_back('{kind: ITEM_WRITE, duration: '0, last: 1'b0,
                               reg_index: idx, reg_data: data});
        plan_win = window_write(plan_win, idx, data);
    endtask

    task automatic plan_settle();
        waveform_q.push_back('{kind: ITEM_SETTLE, duration: '0, last: 1'b0,
                               reg_index: '0, reg_data: '0});
    endtask

    task automatic plan_windows(input logic [31:0] lp, input logic [31:0] ls,
                                input logic [31:0] mk, input logic [31:0] one,
                                input logic [31:0] zero);
        plan_write(nec_ir_pkg::CFG_LEAD_PULSE, lp);
        plan_write(nec_ir_pkg::CFG_LEAD_SPACE, ls);
        plan_write(nec_ir_pkg::CFG_MARK, mk);
        plan_write(nec_ir_pkg::CFG_ONE_SPACE, one);
        plan_write(nec_ir_pkg::CFG_ZERO_SPACE, zero);
    endtask

    task automatic plan_waveform();
        int                  pick;
        int                  n;
        int                  flaw;
        logic                noise;
        logic [7:0]          addr;
        logic [7:0]          cmd;
        logic [31:0]         bits;
        logic [DUR_BITS-1:0] d;
        pick  = $urandom_range(0, 99);
        addr  = 8'($urandom);
        cmd   = 8'($urandom);
        bits  = {~cmd, cmd, ~addr, addr};
        n     = 67;
        flaw  = -1;
        noise = 1'b0;
        case ($urandom_range(0, 7))
            0:       bits = bits ^ (32'h0000_0100 << $urandom_range(0, 7));
            1:       bits = bits ^ (32'h0100_0000 << $urandom_range(0, 7));
            default: ;
        endcase
        if (pick < 50) begin
            n = 67;
        end else if (pick < 60) begin
            n = 67 + $urandom_range(1, 6);
        end else if (pick < 75) begin
            flaw = $urandom_range(0, 66);
            n    = 67 + $urandom_range(0, 3);
        end else if (pick < 90) begin
            n = $urandom_range(1, 66);
            if ($urandom_range(0, 1) == 1) flaw = n - 1;
        end else begin
            n     = $urandom_range(1, 80);
            noise = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            if (noise || i >= 67) d = DUR_BITS'($urandom_range(0, 65535));
            else if (i == flaw)   d = flawed_sample(i);
            else                  d = good_sample(i, bits);
            plan_sample(d, i == n - 1);
        end
    endtask

    task automatic plan_run();
        int phase;
        int phase_end;
        int zero_hi;
        logic [31:0] zero_w;
        plan_win = {nec_ir_pkg::RST_LEAD_PULSE, nec_ir_pkg::RST_LEAD_SPACE,
                    nec_ir_pkg::RST_MARK, nec_ir_pkg::RST_ONE_SPACE,
                    nec_ir_pkg::RST_ZERO_SPACE};

        // short waveforms at reset windows for the short, lead and data failure kinds
        plan_sample(16'd0, 1'b1);
        plan_sample(16'hffff, 1'b0);
        plan_sample(16'd500, 1'b0);
        plan_sample(16'd0, 1'b1);
        plan_sample(16'd9000, 1'b0);
        plan_sample(16'd3999, 1'b0);
        plan_sample(16'd123, 1'b1);
        plan_sample(16'd8000, 1'b0);
        plan_sample(16'd5000, 1'b0);
        plan_sample(16'd701, 1'b0);
        plan_sample(16'd0, 1'b1);
        plan_sample(16'd10000, 1'b0);
        plan_sample(16'd4000, 1'b0);
        plan_sample(16'd400, 1'b0);
        plan_sample(16'd1000, 1'b0);
        plan_sample(16'hffff, 1'b1);
        plan_write(CFG_SPARE, 32'hffff_ffff);
        plan_sample(16'd9500, 1'b0);
        plan_sample(16'd4500, 1'b1);
        plan_settle();

        phase = 0;
        while (beats_planned < BEAT_TARGET || waves_planned < WAVE_TARGET) begin
            if (phase % 3 == 0) plan_settle();
            case (phase % 6)
                0: plan_windows(nec_ir_pkg::RST_LEAD_PULSE, nec_ir_pkg::RST_LEAD_SPACE,
                                nec_ir_pkg::RST_MARK, nec_ir_pkg::RST_ONE_SPACE,
                                nec_ir_pkg::RST_ZERO_SPACE);
                // extremes: full range, single top value, single zero value
                2: plan_windows(32'hffff_0000, 32'hffff_ffff, 32'hffff_0000,
                                32'hffff_ffff, 32'h0000_0000);
                // one and zero windows overlap across 800..1000
                4: plan_windows(nec_ir_pkg::RST_LEAD_PULSE, nec_ir_pkg::RST_LEAD_SPACE,
                                nec_ir_pkg::RST_MARK,
                                {16'd1900, 16'd800}, {16'd1000, 16'd100});
                // inverted lead space window accepts nothing
                5: plan_windows(nec_ir_pkg::RST_LEAD_PULSE, 32'h0000_ffff,
                                nec_ir_pkg::RST_MARK, nec_ir_pkg::RST_ONE_SPACE,
                                nec_ir_pkg::RST_ZERO_SPACE);
                default: begin
                    zero_w  = rand_window(0, 2000, 1000);
                    zero_hi = zero_w[31:16];
                    plan_windows(rand_window(0, 65000, 3000), rand_window(0, 65000, 3000),
                                 rand_window(0, 60000, 1500),
                                 rand_window(zero_hi + 1, zero_hi + 3000, 2000), zero_w);
                end
            endcase
            phase_end = beats_planned + PHASE_BEATS;
            while (beats_planned < phase_end) begin
                plan_waveform();
                if ($urandom_range(0, 9) == 0) plan_settle();
            end
            phase++;
        end
        // drain every status before the run is declared over
        plan_settle();
    endtask

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 0;
        if (r < 9) return $urandom_range(1, 6);
        return $urandom_range(15, 30);
    endfunction

    // ---------------------------------------------------------------- driver

    always @(posedge i_clk) begin
        t_bench_item head;
        logic        beat_busy;
        logic        write_busy;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            i_cfg_valid   <= 1'b0;
            live_win      = {nec_ir_pkg::RST_LEAD_PULSE, nec_ir_pkg::RST_LEAD_SPACE,
                             nec_ir_pkg::RST_MARK, nec_ir_pkg::RST_ONE_SPACE,
                             nec_ir_pkg::RST_ZERO_SPACE};
        end else begin
            beat_busy  = s_axis_tvalid;
            write_busy = i_cfg_valid;
            if (s_axis_tvalid && s_axis_tready) begin
                decode_duration(s_axis_tdata, s_axis_tlast);
                beats_taken++;
                if (s_axis_tlast) waves_taken++;
                beat_busy = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                live_win = window_write(live_win, i_cfg_index, i_cfg_data);
                writes_taken++;
                write_busy = 1'b0;
            end
            // count calm cycles: nothing offered and no status outstanding
            if (s_axis_tvalid || i_cfg_valid || awaited_status_q.size() != 0) quiet_run = 0;
            else if (quiet_run < SETTLE_CYCLES) quiet_run++;

            if (!beat_busy && !write_busy && waveform_q.size() != 0) begin
                head = waveform_q[0];
                case (head.kind)
                    ITEM_SAMPLE: begin
                        if (gap_left != 0) begin
                            gap_left--;
                        end else begin
                            waveform_q.delete(0);
                            s_axis_tdata <= head.duration;
                            s_axis_tlast <= head.last;
                            beat_busy    = 1'b1;
                            if (burst_left > 1) begin
                                burst_left--;
                            end else begin
                                burst_left = $urandom_range(1, 48);
                                gap_left   = next_gap();
                            end
                        end
                    end
                    ITEM_WRITE: begin
                        if (quiet_run == SETTLE_CYCLES) begin
                            waveform_q.delete(0);
                            i_cfg_index <= head.reg_index;
                            i_cfg_data  <= head.reg_data;
                            write_busy  = 1'b1;
                        end
                    end
                    ITEM_SETTLE: begin
                        if (quiet_run == SETTLE_CYCLES) begin
                            waveform_q.delete(0);
                            settles_done++;
                        end
                    end
                    default: ;
                endcase
            end
            s_axis_tvalid <= beat_busy;
            i_cfg_valid   <= write_busy;
        end
    end

    // ---------------------------------------------------------------- monitor

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            failures++;
            if (failures <= 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_status want;
        logic          ready_next;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            cycle_count <= cycle_count + 32'd1;
            if (m_axis_tvalid && m_axis_tready) begin
                statuses_seen++;
                if (awaited_status_q.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: status beat %h with none awaited", $time, m_axis_tdata);
                end else begin
                    want = awaited_status_q.pop_front();
                    codes_seen[want.status] = 1'b1;
                    compare_field("status", 8'(want.status), 8'(m_axis_tdata[3:0]));
                    compare_field("address", want.address, m_axis_tdata[11:4]);
                    compare_field("command", want.command, m_axis_tdata[19:12]);
                    compare_field("fill", 8'd0, 8'(m_axis_tdata[23:20]));
                end
            end
            // stall pattern is picked by bits 9:8 of the cycle count
            case (cycle_count[9:8])
                2'd0:    ready_next = 1'b1;
                2'd1:    ready_next = 1'($urandom_range(0, 1));
                2'd2:    ready_next = (cycle_count[2:0] == 3'd0);
                default: ready_next = (cycle_count[4:0] < 5'd3);
            endcase
            m_axis_tready <= ready_next;
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == STUCK_LIMIT) begin
            $display("no beat moved for %0d cycles", STUCK_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        plan_run();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (waveform_q.size() != 0 || quiet_run != SETTLE_CYCLES) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (awaited_status_q.size() != 0) begin
            failures += awaited_status_q.size();
            $display("%0d awaited status beats never arrived", awaited_status_q.size());
        end
        $display("run: %0d duration beats in %0d waveforms, %0d register writes, %0d pauses",
                 beats_taken, waves_taken, writes_taken, settles_done);
        $display("run: %0d status beats checked, %0d of 9 status codes seen, %0d mismatches",
                 statuses_seen, $countones(codes_seen), failures);
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
